// ===== rtl/dnv_pkg.sv =====
// ----------------------------------------------------------------------------
// dnv_pkg
// Shared types, codes and helpers for the domain name validator.
// ----------------------------------------------------------------------------
package dnv_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned NameCntW   = 9;
  localparam int unsigned LabelCntW  = 7;
  localparam int unsigned NameLenW   = 8;
  localparam int unsigned LabelLenW  = 6;
  localparam int unsigned ErrW       = 4;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 8;

  localparam logic [CharW-1:0]     DotChar      = 8'h2E;
  localparam logic [CharW-1:0]     HyphenChar   = 8'h2D;
  localparam logic [NameCntW-1:0]  NameCntTop   = 9'd511;
  localparam logic [LabelCntW-1:0] LabelCntTop  = 7'd127;

  // Error codes
  localparam logic [ErrW-1:0] ErrNone       = 4'd0;
  localparam logic [ErrW-1:0] ErrNameShort  = 4'd1;
  localparam logic [ErrW-1:0] ErrNameLong   = 4'd2;
  localparam logic [ErrW-1:0] ErrLabelShort = 4'd3;
  localparam logic [ErrW-1:0] ErrLabelLong  = 4'd4;
  localparam logic [ErrW-1:0] ErrBadChar    = 4'd5;
  localparam logic [ErrW-1:0] ErrBadStart   = 4'd6;
  localparam logic [ErrW-1:0] ErrBadEnd     = 4'd7;
  localparam logic [ErrW-1:0] ErrNoDot      = 4'd8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTrailingDot = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMinName     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxName     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMinLabel    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxLabel    = 3'd4;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             is_last;
  } dnv_char_t;

  typedef struct packed {
    logic            name_valid;
    logic [ErrW-1:0] error_code;
  } dnv_result_t;

  // Per-label tracking state
  typedef struct packed {
    logic [LabelCntW-1:0] count;
    logic                 bad_char;
    logic                 first_letter;
    logic                 prev_letter_digit;
  } dnv_label_t;

  function automatic logic dnv_is_letter(input logic [CharW-1:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic dnv_is_digit(input logic [CharW-1:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  // Check one finished label, in priority order
  function automatic logic [ErrW-1:0] dnv_label_err(
    input dnv_label_t           lbl,
    input logic [LabelLenW-1:0] min_len,
    input logic [LabelLenW-1:0] max_len
  );
    logic [ErrW-1:0] err;
    err = ErrNone;
    if (lbl.count < {1'b0, min_len})       err = ErrLabelShort;
    else if (lbl.count > {1'b0, max_len})  err = ErrLabelLong;
    else if (lbl.bad_char)                 err = ErrBadChar;
    else if (!lbl.first_letter)            err = ErrBadStart;
    else if (!lbl.prev_letter_digit)       err = ErrBadEnd;
    return err;
  endfunction

endpackage

// ===== rtl/dnv_char_if.sv =====
// ----------------------------------------------------------------------------
// dnv_char_if
// Character stream channel: valid/ready handshake with one name byte.
// ----------------------------------------------------------------------------
interface dnv_char_if
  import dnv_pkg::*;
();
  logic      valid;
  logic      ready;
  dnv_char_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/dnv_result_if.sv =====
// ----------------------------------------------------------------------------
// dnv_result_if
// Result channel: valid/ready handshake with one check verdict.
// ----------------------------------------------------------------------------
interface dnv_result_if
  import dnv_pkg::*;
();
  logic        valid;
  logic        ready;
  dnv_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/domain_name_validator_unit.sv =====
// ----------------------------------------------------------------------------
// domain_name_validator_unit
// Streaming domain name syntax check: one byte per transfer, one verdict on
// the byte that closes the name.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    char_code[7:0], is_last
//  out_res   out  valid/ready    name_valid, error_code[3:0]
//  cfg_*     in   write enable   cfg_idx[2:0], cfg_wdata[7:0]
//
//  One byte is taken per cycle while in_ch.ready is high; the verdict appears in
//  the output register the cycle after the last byte is taken.
//  Throughput is set by the single-stage state update: one byte per clock while not stalled.
//  A waiting verdict stalls input only if the sink also holds ready low.
//  Synchronous active-low reset clears counters, flags and output valid and
//  loads the register defaults.
// ----------------------------------------------------------------------------
module domain_name_validator_unit
  import dnv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  dnv_char_if.sink            in_ch,
  dnv_result_if.source        out_res,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  // Configuration registers
  logic                 trail_dot_r;
  logic [NameLenW-1:0]  min_name_r;
  logic [NameLenW-1:0]  max_name_r;
  logic [LabelLenW-1:0] min_label_r;
  logic [LabelLenW-1:0] max_label_r;

  // Name state
  logic [NameCntW-1:0]  name_cnt_r, name_cnt_nxt;
  dnv_label_t           label_r, label_nxt;
  logic [ErrW-1:0]      first_err_r, first_err_nxt;

  // Output register
  logic                 out_valid_r;
  dnv_result_t          out_data_r;

  logic                 in_xfer;
  logic                 do_take;
  logic                 is_dot;
  logic                 ld_char;
  logic [NameCntW-1:0]  t_name_cnt;
  dnv_label_t           t_label;
  logic [ErrW-1:0]      t_first_err;
  logic [ErrW-1:0]      fin_first_err;
  logic [ErrW-1:0]      err;

  // Accept while the output slot is free or being drained
  assign in_ch.ready   = !out_valid_r || out_res.ready;
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trail_dot_r <= 1'b0;
      min_name_r  <= 8'd1;
      max_name_r  <= 8'd255;
      min_label_r <= 6'd1;
      max_label_r <= 6'd63;
    end else if (cfg_we) begin
      case (cfg_idx)
        CfgTrailingDot: trail_dot_r <= cfg_wdata[0];
        CfgMinName:     min_name_r  <= cfg_wdata[NameLenW-1:0];
        CfgMaxName:     max_name_r  <= cfg_wdata[NameLenW-1:0];
        CfgMinLabel:    min_label_r <= cfg_wdata[LabelLenW-1:0];
        CfgMaxLabel:    max_label_r <= cfg_wdata[LabelLenW-1:0];
        default: ;
      endcase
    end
  end

  // Apply one character to the name state, then close the name if last
  always_comb begin
    is_dot  = (in_ch.data.char_code == DotChar);
    ld_char = dnv_is_letter(in_ch.data.char_code) || dnv_is_digit(in_ch.data.char_code);
    // the last byte in trailing-dot mode is not taken as a character
    do_take = !in_ch.data.is_last || !trail_dot_r;

    t_name_cnt  = name_cnt_r;
    t_label     = label_r;
    t_first_err = first_err_r;
    if (do_take) begin
      if (name_cnt_r != NameCntTop) t_name_cnt = name_cnt_r + 9'd1;
      if (is_dot) begin
        if (first_err_r == ErrNone)
          t_first_err = dnv_label_err(label_r, min_label_r, max_label_r);
        t_label = '0;
      end else begin
        if (label_r.count == '0)
          t_label.first_letter = dnv_is_letter(in_ch.data.char_code);
        if (label_r.count != LabelCntTop) t_label.count = label_r.count + 7'd1;
        if (!(ld_char || in_ch.data.char_code == HyphenChar)) t_label.bad_char = 1'b1;
        t_label.prev_letter_digit = ld_char;
      end
    end

    // close the last label
    fin_first_err = t_first_err;
    if (t_first_err == ErrNone)
      fin_first_err = dnv_label_err(t_label, min_label_r, max_label_r);

    if (trail_dot_r && !is_dot)                  err = ErrNoDot;
    else if (t_name_cnt < {1'b0, min_name_r})    err = ErrNameShort;
    else if (t_name_cnt > {1'b0, max_name_r})    err = ErrNameLong;
    else                                         err = fin_first_err;

    // next state: cleared after the last byte
    if (in_ch.data.is_last) begin
      name_cnt_nxt  = '0;
      label_nxt     = '0;
      first_err_nxt = ErrNone;
    end else begin
      name_cnt_nxt  = t_name_cnt;
      label_nxt     = t_label;
      first_err_nxt = t_first_err;
    end
  end

  // Advance name state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_cnt_r  <= '0;
      label_r     <= '0;
      first_err_r <= ErrNone;
    end else if (in_xfer) begin
      name_cnt_r  <= name_cnt_nxt;
      label_r     <= label_nxt;
      first_err_r <= first_err_nxt;
    end
  end

  // Hold the verdict until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && in_ch.data.is_last) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.data.is_last) begin
      out_data_r.name_valid <= (err == ErrNone);
      out_data_r.error_code <= err;
    end
  end

endmodule

// ===== rtl/dnv_checker.sv =====
// ----------------------------------------------------------------------------
// dnv_checker
// Port-level checks for the domain name validator, bound to domain_name_validator_unit.
// ----------------------------------------------------------------------------
module dnv_checker
  import dnv_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_is_last,
  input logic            out_valid,
  input logic            out_ready,
  input logic            out_name_valid,
  input logic [ErrW-1:0] out_error_code
);

  // A held verdict stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict dropped while stalled");

  // Valid flag agrees with the error code
  a_valid_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_name_valid == (out_error_code == ErrNone)))
    else $error("name_valid disagrees with error_code");

  // Error code stays within the defined set
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error_code <= ErrNoDot))
    else $error("error_code out of range");

  // An empty output slot never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A byte that is not last produces no verdict
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && in_ready && !in_is_last |=> !out_valid)
    else $error("verdict without last byte");

endmodule

bind domain_name_validator_unit dnv_checker u_dnv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_is_last     (in_ch.data.is_last),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .out_name_valid (out_res.data.name_valid),
  .out_error_code (out_res.data.error_code)
);
